// File: rtl/core/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types, codes and the microcode table of the linear-scan min-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_WAIT       = 4'd0,
    S_DISP       = 4'd1,
    S_DCHK       = 4'd2,
    S_SCAN       = 4'd3,
    S_SCEND      = 4'd4,
    S_SHINIT     = 4'd5,
    S_SHIFT      = 4'd6,
    S_SHEND      = 4'd7,
    S_DEQ        = 4'd8,
    S_ENQ        = 4'd9,
    S_ENQW       = 4'd10,
    S_FULL       = 4'd11,
    S_EMPTY      = 4'd12,
    S_EMIT       = 4'd13,
    S_EMIT_RETRY = 4'd14
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IDLE,
    C_ENQ,
    C_EMPTY,
    C_MORE,
    C_NO_SHIFT,
    C_FULL,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    R_NONE,
    R_ENQ,
    R_DEQ,
    R_EMPTY,
    R_FULL
  } res_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  ld_in;
    logic  clr_idx;
    logic  ld_shift;
    logic  rd;
    logic  cmp;
    logic  mov;
    res_t  res;
    logic  emit;
  } ctl_t;

  typedef struct packed {
    logic take;
    logic enq;
    logic empty;
    logic more;
    logic no_shift;
    logic full;
    logic out_free;
  } flags_t;

  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    c = '{cond: C_ALWAYS, target: S_WAIT, ld_in: 1'b0, clr_idx: 1'b0, ld_shift: 1'b0,
          rd: 1'b0, cmp: 1'b0, mov: 1'b0, res: R_NONE, emit: 1'b0};
    case (s)
      S_WAIT: begin
        c.cond   = C_IDLE;
        c.target = S_WAIT;
        c.ld_in  = 1'b1;
      end
      S_DISP: begin
        c.cond    = C_ENQ;
        c.target  = S_ENQ;
        c.clr_idx = 1'b1;
      end
      S_DCHK: begin
        c.cond   = C_EMPTY;
        c.target = S_EMPTY;
      end
      S_SCAN: begin
        c.cond   = C_MORE;
        c.target = S_SCAN;
        c.rd     = 1'b1;
        c.cmp    = 1'b1;
      end
      S_SCEND: begin
        c.cond   = C_ALWAYS;
        c.target = S_SHINIT;
        c.cmp    = 1'b1;
      end
      S_SHINIT: begin
        c.cond     = C_NO_SHIFT;
        c.target   = S_DEQ;
        c.ld_shift = 1'b1;
      end
      S_SHIFT: begin
        c.cond   = C_MORE;
        c.target = S_SHIFT;
        c.rd     = 1'b1;
        c.mov    = 1'b1;
      end
      S_SHEND: begin
        c.cond   = C_ALWAYS;
        c.target = S_DEQ;
        c.mov    = 1'b1;
      end
      S_DEQ: begin
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
        c.res    = R_DEQ;
      end
      S_ENQ: begin
        c.cond   = C_FULL;
        c.target = S_FULL;
      end
      S_ENQW: begin
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
        c.res    = R_ENQ;
      end
      S_FULL: begin
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
        c.res    = R_FULL;
      end
      S_EMPTY: begin
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
        c.res    = R_EMPTY;
      end
      S_EMIT: begin
        c.cond   = C_OUT_FREE;
        c.target = S_WAIT;
        c.emit   = 1'b1;
      end
      S_EMIT_RETRY: begin
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = S_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mpq_seq.sv
// ----------------------------------------------------------------------------
// mpq_seq
// Microprogram sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module mpq_seq
  import mpq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctl_t   ctl
);

  step_t upc;
  step_t upc_next;
  logic  hit;

  assign ctl = ucode(upc);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:   hit = 1'b1;
      C_IDLE:     hit = !flags.take;
      C_ENQ:      hit = flags.enq;
      C_EMPTY:    hit = flags.empty;
      C_MORE:     hit = flags.more;
      C_NO_SHIFT: hit = flags.no_shift;
      C_FULL:     hit = flags.full;
      C_OUT_FREE: hit = flags.out_free;
      default:    hit = 1'b1;
    endcase
    upc_next = hit ? ctl.target : step_t'(upc + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: rtl/core/min_priority_queue_linear_scan_top.sv
// ----------------------------------------------------------------------------
// min_priority_queue_linear_scan_top
// Min-priority queue over an unsorted array in arrival order.
// Dequeue scans all n entries, then moves the entries after the minimum down
//   one place (no shift if it is last); both passes use the one RAM read port.
// One item in flight; the next input transfer is taken after the result is loaded.
// Synchronous reset empties the queue; entry storage is not cleared.
// ----------------------------------------------------------------------------
module min_priority_queue_linear_scan_top
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output status_t                  status,
  output logic signed [DATA_W-1:0] value_res,
  output logic [COUNT_W-1:0]       count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ctl_t   ctl;
  flags_t flags;

  logic                     op_r;
  logic [DATA_W-1:0]        val_r;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            idx;
  logic                     pend;
  logic [AW-1:0]            pidx;
  logic [AW-1:0]            bidx;
  logic signed [DATA_W-1:0] best;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_value;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  logic              out_free;
  logic              take_min;

  mpq_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  mpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign in_stall = !ctl.ld_in || rst;
  assign out_free = !out_valid || !out_stall;
  assign take_min = ctl.cmp && pend && ((pidx == '0) || ($signed(rdata) < best));

  always_comb begin
    flags.take     = in_valid;
    flags.enq      = (op_r == OP_ENQ);
    flags.empty    = (cnt == '0);
    flags.more     = ((idx + CW'(1)) < cnt);
    flags.no_shift = ((CW'(bidx) + CW'(1)) >= cnt);
    flags.full     = (cnt >= CW'(CAPACITY));
    flags.out_free = out_free;
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = val_r;
    if (ctl.mov && pend) begin
      we    = 1'b1;
      waddr = pidx - AW'(1);
      wdata = rdata;
    end else if (ctl.res == R_ENQ) begin
      we = 1'b1;
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (ctl.ld_in && in_valid) begin
      op_r  <= op;
      val_r <= value;
    end
    if (ctl.clr_idx) begin
      idx <= '0;
    end else if (ctl.ld_shift) begin
      idx <= CW'(bidx) + CW'(1);
    end else if (ctl.rd) begin
      idx <= idx + CW'(1);
    end
    pidx <= idx[AW-1:0];
    if (take_min) begin
      best <= $signed(rdata);
      bidx <= pidx;
    end
    case (ctl.res)
      R_ENQ: begin
        res_status <= ST_ENQ;
        res_value  <= '0;
      end
      R_DEQ: begin
        res_status <= ST_DEQ;
        res_value  <= best;
      end
      R_EMPTY: begin
        res_status <= ST_EMPTY;
        res_value  <= '0;
      end
      R_FULL: begin
        res_status <= ST_FULL;
        res_value  <= '0;
      end
      default: begin
      end
    endcase
    if (ctl.emit && out_free) begin
      status    <= res_status;
      value_res <= res_value;
      count     <= COUNT_W'(cnt);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= ctl.rd;
      if (ctl.res == R_ENQ) begin
        cnt <= cnt + CW'(1);
      end else if (ctl.res == R_DEQ) begin
        cnt <= cnt - CW'(1);
      end
      if (ctl.emit && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/mpq_chk.sv
// ----------------------------------------------------------------------------
// mpq_chk
// Port-level checks of the min-priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_chk
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input status_t                  status,
  input logic signed [DATA_W-1:0] value_res,
  input logic [COUNT_W-1:0]       count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_res)
      && $stable(count))
    else $error("result changed while stalled");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DEQ) |-> (value_res == '0))
    else $error("nonzero value on a non-dequeue result");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (count == '0))
    else $error("empty result with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
    else $error("full result with count below capacity");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind min_priority_queue_linear_scan_top mpq_chk #(.CAPACITY(CAPACITY)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .value_res (value_res),
  .count     (count)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the linear-scan min-priority queue. A directed table covers
// the empty and full cases, the signed extremes and the earliest-first rule
// on equal minima. Random enqueue/dequeue traffic follows with varying fill
// bias. Each result is checked field by field against the table or a model
// queue in arrival order. Both handshakes see random idle and stall bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mpq_pkg::*;

  localparam int QDEPTH   = 16;
  localparam int DRAIN_CYC = 2 * QDEPTH + 10;
  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM = 600;
  localparam int PHASE_LEN = 60;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic [COUNT_W-1:0]       count;
  } pq_result_t;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               reps;
    logic                     rnd;
    logic                     typed;
    status_t                  exp_status;
    logic signed [DATA_W-1:0] exp_value;
    logic [COUNT_W-1:0]       exp_count;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, 1'b1, ST_EMPTY, 32'h0000_0000, 5'd0},
    '{OP_ENQ, 32'h7FFF_FFFF, 5'd1,  1'b0, 1'b1, ST_ENQ,   32'h0000_0000, 5'd1},
    '{OP_ENQ, 32'h8000_0000, 5'd1,  1'b0, 1'b1, ST_ENQ,   32'h0000_0000, 5'd2},
    '{OP_ENQ, 32'h0000_0000, 5'd1,  1'b0, 1'b1, ST_ENQ,   32'h0000_0000, 5'd3},
    '{OP_ENQ, 32'hFFFF_FFFF, 5'd1,  1'b0, 1'b1, ST_ENQ,   32'h0000_0000, 5'd4},
    '{OP_ENQ, 32'h0000_0005, 5'd1,  1'b0, 1'b0, ST_ENQ,   32'h0000_0000, 5'd0},
    '{OP_ENQ, 32'hFFFF_FFFF, 5'd1,  1'b0, 1'b0, ST_ENQ,   32'h0000_0000, 5'd0},
    '{OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, 1'b1, ST_DEQ,   32'h8000_0000, 5'd5},
    '{OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, 1'b0, ST_DEQ,   32'h0000_0000, 5'd0},
    '{OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, 1'b0, ST_DEQ,   32'h0000_0000, 5'd0},
    '{OP_ENQ, 32'h0000_0000, 5'd13, 1'b1, 1'b0, ST_ENQ,   32'h0000_0000, 5'd0},
    '{OP_ENQ, 32'h1234_5678, 5'd1,  1'b0, 1'b1, ST_FULL,  32'h0000_0000, 5'd16},
    '{OP_ENQ, 32'h8000_0000, 5'd1,  1'b0, 1'b1, ST_FULL,  32'h0000_0000, 5'd16},
    '{OP_DEQ, 32'h0000_0000, 5'd16, 1'b1, 1'b0, ST_DEQ,   32'h0000_0000, 5'd0},
    '{OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, 1'b1, ST_EMPTY, 32'h0000_0000, 5'd0},
    '{OP_ENQ, 32'h8000_0000, 5'd1,  1'b0, 1'b1, ST_ENQ,   32'h0000_0000, 5'd1},
    '{OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, 1'b1, ST_DEQ,   32'h8000_0000, 5'd0},
    '{OP_ENQ, 32'h7FFF_FFFF, 5'd1,  1'b0, 1'b1, ST_ENQ,   32'h0000_0000, 5'd1},
    '{OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, 1'b1, ST_DEQ,   32'h7FFF_FFFF, 5'd0},
    '{OP_DEQ, 32'hFFFF_FFFF, 5'd1,  1'b0, 1'b1, ST_EMPTY, 32'h0000_0000, 5'd0}
  };

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic                     op        = OP_ENQ;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  status_t                  status;
  logic signed [DATA_W-1:0] value_res;
  logic [COUNT_W-1:0]       count;

  logic signed [DATA_W-1:0] model_entries[$];
  pq_result_t               awaited_results[$];
  pq_result_t               want_res;
  int                       errors      = 0;
  int                       items_in    = 0;
  int                       results_out = 0;
  int                       status_hits[4] = '{0, 0, 0, 0};
  int                       idle_pct    = 0;
  int                       stall_pct   = 0;
  int                       stall_left  = 0;

  min_priority_queue_linear_scan_top #(
    .CAPACITY(QDEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .value_res(value_res),
    .count    (count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Queue kept in arrival order; dequeue removes the earliest smallest entry.
  function automatic pq_result_t min_queue_outcome(input logic o,
                                                   input logic signed [DATA_W-1:0] v);
    pq_result_t res;
    int         best;
    res.value = '0;
    if (o == OP_ENQ) begin
      if (model_entries.size() >= QDEPTH) begin
        res.status = ST_FULL;
      end else begin
        model_entries.push_back(v);
        res.status = ST_ENQ;
      end
    end else if (model_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < model_entries.size(); i++) begin
        if (model_entries[i] < model_entries[best]) best = i;
      end
      res.value  = model_entries[best];
      model_entries.delete(best);
      res.status = ST_DEQ;
    end
    res.count = COUNT_W'(model_entries.size());
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return DATA_W'($signed($urandom_range(0, 8)) - 4);
      7:          return 32'h7FFF_FFFF;
      8:          return 32'h8000_0000;
      default:    return DATA_W'($urandom_range(0, 255)) << $urandom_range(0, 24);
    endcase
  endfunction

  task automatic send_item(input logic o, input logic signed [DATA_W-1:0] v,
                           input logic typed, input pq_result_t typed_res);
    pq_result_t pred;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      op       <= 1'($urandom_range(0, 1));
      value    <= $urandom;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = min_queue_outcome(o, v);
    awaited_results.push_back(typed ? typed_res : pred);
    items_in++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_out++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d value_res %0d count %0d",
               status, value_res, count);
        errors++;
      end else begin
        want_res = awaited_results.pop_front();
        status_hits[want_res.status]++;
        if (status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, status);
          errors++;
        end
        if (value_res !== want_res.value) begin
          $error("value_res: expected %0d, got %0d", want_res.value, value_res);
          errors++;
        end
        if (count !== want_res.count) begin
          $error("count: expected %0d, got %0d", want_res.count, count);
          errors++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    pq_result_t row_res;
    logic       rnd_op;
    int         enq_pct;

    idle_pct  = 30;
    stall_pct = 30;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      row_res = '{status: DIRECTED[r].exp_status, value: DIRECTED[r].exp_value,
                  count: DIRECTED[r].exp_count};
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        send_item(DIRECTED[r].op, DIRECTED[r].rnd ? pick_value() : DIRECTED[r].value,
                  DIRECTED[r].typed, row_res);
      end
    end

    enq_pct = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 3))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          2:       enq_pct = 85;
          default: enq_pct = 60;
        endcase
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
        if (n >= N_RANDOM - PHASE_LEN) begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      end
      rnd_op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      send_item(rnd_op, pick_value(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d input transfers and %0d result transfers.", items_in, results_out);
    $display("Statuses seen: %0d enqueued, %0d dequeued, %0d empty, %0d full.",
             status_hits[ST_ENQ], status_hits[ST_DEQ], status_hits[ST_EMPTY],
             status_hits[ST_FULL]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout with %0d results outstanding", awaited_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
